@@ rtl/rrtt_pkg.sv @@
// shared types and constants for the round-robin thread table
`default_nettype none

package rrtt_pkg;

	localparam int MaxThreads = 8;
	localparam int SLOT_W     = $clog2(MaxThreads);
	localparam int ID_W       = 32;
	localparam int TICK_W     = 32;
	localparam int CMD_W      = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_KILL   = 3'd1,
		CMD_SLEEP  = 3'd2,
		CMD_SWITCH = 3'd3,
		CMD_FLAGS  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_NOREADY = 2'd2,
		STS_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ADD_LINK,
		S_KILL_LINK,
		S_WALK_RD,
		S_WALK_CHK,
		S_FIN_RD,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TICK_W-1:0] sleep_ticks;
		logic [SLOT_W-1:0] target_slot;
		logic              sleep_flag;
		logic              block_flag;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] running_slot;
		logic [ID_W-1:0]   running_id;
		logic [SLOT_W-1:0] added_slot;
		logic [ID_W-1:0]   added_id;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic add_link;
		logic kill_link;
		logic walk_issue;
		logic walk_chk;
		logic result;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t op;
		logic ring;
		logic full;
		logic kill_last;
		logic ready;
		logic walk_last;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/rrtt_ctrl.sv @@
// sequencing state machine for the thread table
`default_nettype none

module rrtt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rrtt_pkg::sts_t sts,
	output rrtt_pkg::ctl_t     ctl,
	output logic               busy,
	output logic               done
);
	import rrtt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (sts.op)
					CMD_ADD: begin
						state_d = (sts.ring && !sts.full) ? S_ADD_LINK : S_FIN_RD;
					end
					CMD_KILL: begin
						state_d = (sts.ring && !sts.kill_last) ? S_KILL_LINK : S_FIN_RD;
					end
					CMD_SWITCH: begin
						state_d = sts.ring ? S_WALK_CHK : S_FIN_RD;
					end
					default: state_d = S_FIN_RD;
				endcase
			end
			S_ADD_LINK:  state_d = S_FIN_RD;
			S_KILL_LINK: state_d = S_WALK_RD;
			S_WALK_RD:   state_d = S_WALK_CHK;
			S_WALK_CHK: begin
				if (sts.ready || sts.walk_last) state_d = S_FIN_RD;
			end
			S_FIN_RD:    state_d = S_RESULT;
			S_RESULT:    state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		busy           = 1'b1;
		done           = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			S_EXEC:      ctl.exec       = 1'b1;
			S_ADD_LINK:  ctl.add_link   = 1'b1;
			S_KILL_LINK: ctl.kill_link  = 1'b1;
			S_WALK_RD:   ctl.walk_issue = 1'b1;
			S_WALK_CHK:  ctl.walk_chk   = 1'b1;
			S_FIN_RD:    ;
			S_RESULT: begin
				ctl.result = 1'b1;
				done       = 1'b1;
			end
			default:     ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/rrtt_dpath.sv @@
// thread table storage, ring links, walk pointer and result registers
`default_nettype none

module rrtt_dpath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rrtt_pkg::req_t request,
	input  wire rrtt_pkg::ctl_t ctl,
	output rrtt_pkg::sts_t      sts,
	output rrtt_pkg::rsp_t      result
);
	import rrtt_pkg::*;

	// table memories, one registered read port shared by all
	logic [SLOT_W-1:0] fwd_mem   [MaxThreads];
	logic [SLOT_W-1:0] bwd_mem   [MaxThreads];
	logic              slp_mem   [MaxThreads];
	logic              blk_mem   [MaxThreads];
	logic [ID_W-1:0]   ident_mem [MaxThreads];
	logic [TICK_W-1:0] dur_mem   [MaxThreads];

	// control state
	logic [SLOT_W-1:0]     cur_q;
	logic [ID_W-1:0]       id_q;
	logic                  ring_q;
	logic [MaxThreads-1:0] used_q;

	// per-request working registers
	req_t              req_q;
	status_t           status_q;
	logic [SLOT_W-1:0] add_slot_q;
	logic [ID_W-1:0]   add_id_q;
	logic [SLOT_W-1:0] new_q;
	logic [SLOT_W-1:0] prev_q;
	logic [SLOT_W-1:0] nxt_q;
	logic [SLOT_W-1:0] fail_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W-1:0] cnt_q;

	// registered read data
	logic [SLOT_W-1:0] rd_fwd_q;
	logic [SLOT_W-1:0] rd_bwd_q;
	logic              rd_slp_q;
	logic              rd_blk_q;
	logic [ID_W-1:0]   rd_ident_q;

	cmd_t              op;
	logic              full;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] new_slot;
	logic              ready;
	logic              walk_last;
	logic [SLOT_W-1:0] rd_addr;

	logic              fwd_we;
	logic [SLOT_W-1:0] fwd_wa;
	logic [SLOT_W-1:0] fwd_wd;
	logic              bwd_we;
	logic [SLOT_W-1:0] bwd_wa;
	logic [SLOT_W-1:0] bwd_wd;
	logic              slp_we;
	logic              blk_we;
	logic [SLOT_W-1:0] flag_wa;
	logic              slp_wd;
	logic              blk_wd;
	logic              ident_we;
	logic              dur_we;

	assign op        = cmd_t'(req_q.command);
	assign full      = &used_q;
	assign new_slot  = ring_q ? free_idx : '0;
	assign ready     = !rd_slp_q && !rd_blk_q;
	assign walk_last = (cnt_q == SLOT_W'(MaxThreads - 1));

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = MaxThreads - 1; i >= 0; i--) begin
			if (!used_q[i]) free_idx = SLOT_W'(i);
		end
	end

	// walk hops follow the link just read, one slot a cycle
	always_comb begin
		if (ctl.walk_chk || (ctl.exec && op == CMD_SWITCH)) begin
			rd_addr = rd_fwd_q;
		end else if (ctl.walk_issue) begin
			rd_addr = nxt_q;
		end else begin
			rd_addr = cur_q;
		end
	end

	always_comb begin
		fwd_we   = 1'b0;
		fwd_wa   = new_slot;
		fwd_wd   = ring_q ? cur_q : '0;
		bwd_we   = 1'b0;
		bwd_wa   = new_slot;
		bwd_wd   = ring_q ? rd_bwd_q : '0;
		slp_we   = 1'b0;
		blk_we   = 1'b0;
		flag_wa  = new_slot;
		slp_wd   = 1'b0;
		blk_wd   = 1'b0;
		ident_we = 1'b0;
		dur_we   = 1'b0;
		if (ctl.exec) begin
			case (op)
				CMD_ADD: begin
					if (!ring_q || !full) begin
						fwd_we   = 1'b1;
						bwd_we   = 1'b1;
						slp_we   = 1'b1;
						blk_we   = 1'b1;
						ident_we = 1'b1;
					end
				end
				CMD_SLEEP: begin
					if (ring_q) begin
						slp_we  = 1'b1;
						flag_wa = cur_q;
						slp_wd  = 1'b1;
						dur_we  = 1'b1;
					end
				end
				CMD_FLAGS: begin
					slp_we  = 1'b1;
					blk_we  = 1'b1;
					flag_wa = req_q.target_slot;
					slp_wd  = req_q.sleep_flag;
					blk_wd  = req_q.block_flag;
				end
				default: ;
			endcase
		end
		// splice the new slot in just before the current one
		if (ctl.add_link) begin
			fwd_we = 1'b1;
			fwd_wa = prev_q;
			fwd_wd = new_q;
			bwd_we = 1'b1;
			bwd_wa = cur_q;
			bwd_wd = new_q;
		end
		// close the ring over the killed slot
		if (ctl.kill_link) begin
			fwd_we = 1'b1;
			fwd_wa = prev_q;
			fwd_wd = nxt_q;
			bwd_we = 1'b1;
			bwd_wa = nxt_q;
			bwd_wd = prev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fwd_we)   fwd_mem[fwd_wa]     <= fwd_wd;
		if (bwd_we)   bwd_mem[bwd_wa]     <= bwd_wd;
		if (slp_we)   slp_mem[flag_wa]    <= slp_wd;
		if (blk_we)   blk_mem[flag_wa]    <= blk_wd;
		if (ident_we) ident_mem[new_slot] <= id_q;
		if (dur_we)   dur_mem[cur_q]      <= req_q.sleep_ticks;
		rd_fwd_q   <= fwd_mem[rd_addr];
		rd_bwd_q   <= bwd_mem[rd_addr];
		rd_slp_q   <= slp_mem[rd_addr];
		rd_blk_q   <= blk_mem[rd_addr];
		rd_ident_q <= ident_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			id_q   <= '0;
			ring_q <= 1'b0;
			used_q <= '0;
		end else begin
			if (ctl.exec) begin
				case (op)
					CMD_ADD: begin
						id_q <= id_q + ID_W'(1);
						if (!ring_q) begin
							cur_q     <= '0;
							ring_q    <= 1'b1;
							used_q[0] <= 1'b1;
						end else if (!full) begin
							used_q[free_idx] <= 1'b1;
						end
					end
					CMD_KILL: begin
						if (ring_q) begin
							used_q[cur_q] <= 1'b0;
							if (rd_fwd_q == cur_q) ring_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (ctl.walk_chk) begin
				if (ready) begin
					cur_q <= ptr_q;
				end else if (walk_last) begin
					cur_q <= fail_q;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q      <= request;
			status_q   <= STS_OK;
			add_slot_q <= '0;
			add_id_q   <= '0;
		end
		if (ctl.exec) begin
			case (op)
				CMD_ADD: begin
					if (ring_q && full) begin
						status_q <= STS_FULL;
					end else begin
						add_slot_q <= new_slot;
						add_id_q   <= id_q;
						new_q      <= new_slot;
						prev_q     <= rd_bwd_q;
					end
				end
				CMD_KILL: begin
					if (!ring_q) begin
						status_q <= STS_EMPTY;
					end else begin
						nxt_q  <= rd_fwd_q;
						prev_q <= rd_bwd_q;
						fail_q <= rd_fwd_q;
					end
				end
				CMD_SLEEP: begin
					if (!ring_q) status_q <= STS_EMPTY;
				end
				CMD_SWITCH: begin
					if (!ring_q) begin
						status_q <= STS_EMPTY;
					end else begin
						ptr_q  <= rd_fwd_q;
						cnt_q  <= '0;
						fail_q <= cur_q;
					end
				end
				default: ;
			endcase
		end
		if (ctl.walk_issue) begin
			ptr_q <= nxt_q;
			cnt_q <= '0;
		end
		if (ctl.walk_chk && !ready) begin
			if (walk_last) begin
				status_q <= STS_NOREADY;
			end else begin
				ptr_q <= rd_fwd_q;
				cnt_q <= cnt_q + SLOT_W'(1);
			end
		end
	end

	assign sts.op        = op;
	assign sts.ring      = ring_q;
	assign sts.full      = full;
	assign sts.kill_last = (rd_fwd_q == cur_q);
	assign sts.ready     = ready;
	assign sts.walk_last = walk_last;

	assign result.status       = status_q;
	assign result.running_slot = ring_q ? cur_q : '0;
	assign result.running_id   = ring_q ? rd_ident_q : '0;
	assign result.added_slot   = add_slot_q;
	assign result.added_id     = add_id_q;

	a_empty_no_used: assert property (@(posedge clk) disable iff (!arst_n)
		!ring_q |-> (used_q == '0))
		else $error("slots marked used with no ring");

	a_cur_used: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.result && ring_q) |-> used_q[cur_q])
		else $error("current slot is not in use at result");

	a_new_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add_link |-> (new_q != cur_q && new_q != prev_q))
		else $error("added slot collides with a ring neighbor");

endmodule

`default_nettype wire

@@ rtl/round_robin_thread_table_core.sv @@
// top level of the round-robin thread table
`default_nettype none

// Round-robin thread table: eight slots linked in a circular ring, one of
// them the current thread. A request is taken when start is high and busy
// is low; busy stays high until the cycle after the result. The result
// sits on the result port for exactly one cycle with done high and must be
// taken then, since there is no way to hold it off. Set flags, sleep, a
// full add, a kill of the last thread and requests on an empty table go
// through execute, final read and result; add also writes the links (the
// ring splice needs a second write to the link memories); switch walks
// up to 8 slots; kill closes the ring and walks. One ring hop per cycle,
// set by the single read port of the link and flag memories.
// Reset clears the ring and the slot-used bits at once; no clearing pass.
module round_robin_thread_table_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire rrtt_pkg::req_t request,
	output logic                done,
	output rrtt_pkg::rsp_t      result
);
	import rrtt_pkg::*;

	// command strobes and status between sequencer and datapath
	ctl_t ctl;
	sts_t sts;

	rrtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// table memories, walk pointer and result registers
	rrtt_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.sts     (sts),
		.result  (result)
	);

endmodule

`default_nettype wire
